FILE: design/btdc_pkg.sv
`timescale 1ns / 1ps

package btdc_pkg;

  // tilt and filter state width, 1/256 degree
  localparam int TiltW = 18;
  typedef logic signed [TiltW-1:0] tilt_t;

  // shared multiplier operand and product widths
  localparam int MulAW = 35;
  localparam int MulBW = 18;
  localparam int MulPW = MulAW + MulBW;

  // divider widths
  localparam int NumW = 44;
  localparam int DenW = 18;

  // cordic datapath widths
  localparam int CxW       = 27;
  localparam int CzW       = 28;
  localparam int AtanDepth = 24;
  localparam int AtanIdxW  = 5;
  localparam int HalfTurn  = 180 * 65536;

  typedef enum logic [1:0] {
    MODE_INIT,
    MODE_STOP,
    MODE_FWD,
    MODE_REV
  } mode_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CORD,
    S_GYR,
    S_FA,
    S_FB,
    S_GA,
    S_GB,
    S_TILT,
    S_MODE,
    S_KP,
    S_LIM,
    S_DIV,
    S_DRV,
    S_OUT
  } state_e;

  typedef enum logic [2:0] {
    REG_COEF_A,
    REG_COEF_B,
    REG_GYRO_GAIN,
    REG_KP_GAIN,
    REG_KD_GAIN,
    REG_PWM_MAX,
    REG_DEAD_BAND
  } reg_e;

  // divider handshake
  typedef struct packed {
    logic start;
    logic rev;
  } div_ctrl_t;

  // atan(2^-i) in degree*65536
  function automatic logic [21:0] atan_lut(input logic [AtanIdxW-1:0] i);
    logic [21:0] r;
    unique case (i)
      5'd0:    r = 22'd2949120;
      5'd1:    r = 22'd1740967;
      5'd2:    r = 22'd919879;
      5'd3:    r = 22'd466945;
      5'd4:    r = 22'd234379;
      5'd5:    r = 22'd117305;
      5'd6:    r = 22'd58666;
      5'd7:    r = 22'd29335;
      5'd8:    r = 22'd14668;
      5'd9:    r = 22'd7334;
      5'd10:   r = 22'd3667;
      5'd11:   r = 22'd1833;
      5'd12:   r = 22'd917;
      5'd13:   r = 22'd458;
      5'd14:   r = 22'd229;
      5'd15:   r = 22'd115;
      5'd16:   r = 22'd57;
      5'd17:   r = 22'd29;
      5'd18:   r = 22'd14;
      5'd19:   r = 22'd7;
      5'd20:   r = 22'd4;
      5'd21:   r = 22'd2;
      5'd22:   r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

  // saturate to the tilt range
  function automatic tilt_t sat18(input logic signed [39:0] v);
    tilt_t r;
    if (v > 40'sd131071) begin
      r = 18'sd131071;
    end else if (v < -40'sd131072) begin
      r = -18'sd131072;
    end else begin
      r = v[TiltW-1:0];
    end
    return r;
  endfunction

endpackage

FILE: design/btdc_if.sv
`timescale 1ns / 1ps

// sensor request channel
interface btdc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] gyro_z;
  logic               button;

  modport source (output valid, accel_x, accel_y, gyro_z, button, input ready);
  modport sink   (input valid, accel_x, accel_y, gyro_z, button, output ready);
endinterface

// drive result channel
interface btdc_out_if;
  logic               valid;
  logic               ready;
  logic [9:0]         fwd_drive;
  logic [9:0]         rev_drive;
  logic [1:0]         mode;
  logic signed [17:0] tilt;

  modport source (output valid, fwd_drive, rev_drive, mode, tilt, input ready);
  modport sink   (input valid, fwd_drive, rev_drive, mode, tilt, output ready);
endinterface

FILE: design/balance_tilt_drive_controller_top.sv
`timescale 1ns / 1ps
// a request passes the cordic, gyro, filter, tilt and mode states; a drive update adds the kp,
//   limit, divide and drive states, and the 44-step divider dominates the drive path
// one request in flight: a new request is accepted only after the previous result is taken
// one shared multiplier serves gyro scaling, both filters and the drive terms
// reset: asynchronous active low; filters zero, init mode, extremes at +-26, drives zero,
//   registers at their documented defaults
module balance_tilt_drive_controller_top #(
  parameter int PWM_BITS     = 10,
  parameter int CORDIC_ITERS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  btdc_in_if.sink     in_i,
  btdc_out_if.source  out_o
);

  localparam int Iters   = (CORDIC_ITERS < btdc_pkg::AtanDepth) ? CORDIC_ITERS
                                                                 : btdc_pkg::AtanDepth;
  localparam int LimBits = (PWM_BITS < 10) ? PWM_BITS : 10;
  localparam logic [9:0] LimMask = 10'((32'd1 << LimBits) - 32'd1);
  localparam int CxW = btdc_pkg::CxW;
  localparam int CzW = btdc_pkg::CzW;

  // configuration registers
  logic [15:0] coef_a_q, coef_b_q, gyro_gain_q, kp_gain_q, kd_gain_q;
  logic [9:0]  pwm_max_q;
  logic [11:0] dead_band_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a_q    <= 16'd324;
      coef_b_q    <= 16'd32443;
      gyro_gain_q <= 16'd1000;
      kp_gain_q   <= 16'd1580;
      kd_gain_q   <= 16'd0;
      pwm_max_q   <= 10'd1023;
      dead_band_q <= 12'd26;
    end else if (cfg_we_i) begin
      case (btdc_pkg::reg_e'(cfg_idx_i))
        btdc_pkg::REG_COEF_A:    coef_a_q    <= cfg_data_i;
        btdc_pkg::REG_COEF_B:    coef_b_q    <= cfg_data_i;
        btdc_pkg::REG_GYRO_GAIN: gyro_gain_q <= cfg_data_i;
        btdc_pkg::REG_KP_GAIN:   kp_gain_q   <= cfg_data_i;
        btdc_pkg::REG_KD_GAIN:   kd_gain_q   <= cfg_data_i;
        btdc_pkg::REG_PWM_MAX:   pwm_max_q   <= cfg_data_i[9:0];
        btdc_pkg::REG_DEAD_BAND: dead_band_q <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  btdc_pkg::state_e state_q, state_d;
  btdc_pkg::mode_e  mode_q;

  logic [btdc_pkg::AtanIdxW-1:0] cnt_q;
  logic                          zero_q;
  logic                          btn_q;
  logic                          drv_rev_q;
  logic signed [15:0]            gz_q;
  logic signed [CxW-1:0]         cx_q, cy_q;
  logic signed [CzW-1:0]         cz_q;
  btdc_pkg::tilt_t               acc_ang_q, gyr_q, accel_filt_q, gyro_filt_q;
  btdc_pkg::tilt_t               tilt_q, pos_ext_q, neg_ext_q;
  logic signed [39:0]            acc_q;
  logic [9:0]                    fwd_hold_q, rev_hold_q;

  logic signed [btdc_pkg::MulAW-1:0] mul_a;
  logic signed [btdc_pkg::MulBW-1:0] mul_b;
  logic signed [btdc_pkg::MulPW-1:0] prod;
  btdc_pkg::div_ctrl_t               div_ctrl;
  logic                              div_done;
  logic signed [btdc_pkg::NumW-1:0]  quot;

  logic [9:0] lim;
  assign lim = pwm_max_q & LimMask;

  btdc_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  btdc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .num_i  (prod[btdc_pkg::NumW-1:0]),
    .den_i  (drv_rev_q ? neg_ext_q : pos_ext_q),
    .done_o (div_done),
    .quot_o (quot)
  );

  // cordic step
  logic signed [CxW-1:0] nx, ny;
  logic signed [CzW-1:0] nz, at;
  always_comb begin
    at = CzW'($signed({1'b0, btdc_pkg::atan_lut(cnt_q)}));
    if (cy_q > 0) begin
      nx = cx_q + (cy_q >>> cnt_q);
      ny = cy_q - (cx_q >>> cnt_q);
      nz = cz_q + at;
    end else begin
      nx = cx_q - (cy_q >>> cnt_q);
      ny = cy_q + (cx_q >>> cnt_q);
      nz = cz_q - at;
    end
  end

  // cordic start from the request
  logic signed [16:0]    ax, ay;
  logic signed [CxW-1:0] x0, y0;
  logic signed [CzW-1:0] z0;
  always_comb begin
    ax = 17'(in_i.accel_x);
    ay = 17'(in_i.accel_y);
    if (ax < 0) begin
      ax = -ax;
      ay = -ay;
      z0 = (in_i.accel_y >= 0) ? CzW'(btdc_pkg::HalfTurn) : -CzW'(btdc_pkg::HalfTurn);
    end else begin
      z0 = '0;
    end
    x0 = CxW'($signed({ax, 8'b0}));
    y0 = CxW'($signed({ay, 8'b0}));
  end

  // result scaling and filter sums
  logic signed [CzW:0]  ang_r;
  btdc_pkg::tilt_t      acc_ang, gyr, filt_new, tilt_new;
  logic signed [39:0]   lp_sum, gyr_sum;
  always_comb begin
    ang_r    = (-(CzW+1)'(cz_q) + (CzW+1)'(128)) >>> 8;
    acc_ang  = zero_q ? '0 : btdc_pkg::sat18(40'(ang_r));
    gyr_sum  = ($signed(prod[39:0]) + 40'sd128) >>> 8;
    gyr      = btdc_pkg::sat18(gyr_sum);
    lp_sum   = (acc_q + $signed(prod[39:0]) + 40'sd16384) >>> 15;
    filt_new = btdc_pkg::sat18(lp_sum);
    tilt_new = btdc_pkg::sat18(40'(accel_filt_q) + 40'(filt_new));
  end

  // dead band compares
  logic signed [18:0] db_s, tilt_s;
  logic               go_fwd, go_rev;
  always_comb begin
    db_s   = $signed({7'b0, dead_band_q});
    tilt_s = 19'(tilt_q);
    go_fwd = tilt_s >= db_s;
    go_rev = tilt_s <= -db_s;
  end

  // drive finish: subtract rate term, truncate, clamp
  logic signed [45:0] dsum, dq;
  logic [9:0]         drv;
  always_comb begin
    dsum = 46'(quot) - 46'($signed(prod[32:0]));
    dq   = ((dsum < 0) ? (dsum + 46'sd255) : dsum) >>> 8;
    if (dq < 0) begin
      drv = '0;
    end else if (dq > $signed({36'b0, lim})) begin
      drv = lim;
    end else begin
      drv = dq[9:0];
    end
  end

  // sequencer next state and multiplier operands
  always_comb begin
    state_d      = state_q;
    mul_a        = '0;
    mul_b        = '0;
    div_ctrl     = '0;
    div_ctrl.rev = drv_rev_q;
    unique case (state_q)
      btdc_pkg::S_IDLE: if (in_i.valid) state_d = btdc_pkg::S_CORD;
      btdc_pkg::S_CORD: if (cnt_q == btdc_pkg::AtanIdxW'(Iters - 1)) state_d = btdc_pkg::S_GYR;
      btdc_pkg::S_GYR: begin
        mul_a   = btdc_pkg::MulAW'(gz_q);
        mul_b   = $signed({2'b0, gyro_gain_q});
        state_d = btdc_pkg::S_FA;
      end
      btdc_pkg::S_FA: begin
        mul_a   = $signed({19'b0, coef_a_q});
        mul_b   = acc_ang_q;
        state_d = btdc_pkg::S_FB;
      end
      btdc_pkg::S_FB: begin
        mul_a   = $signed({19'b0, coef_b_q});
        mul_b   = accel_filt_q;
        state_d = btdc_pkg::S_GA;
      end
      btdc_pkg::S_GA: begin
        mul_a   = $signed({19'b0, coef_a_q});
        mul_b   = gyr_q;
        state_d = btdc_pkg::S_GB;
      end
      btdc_pkg::S_GB: begin
        mul_a   = $signed({19'b0, coef_b_q});
        mul_b   = gyro_filt_q;
        state_d = btdc_pkg::S_TILT;
      end
      btdc_pkg::S_TILT: state_d = btdc_pkg::S_MODE;
      btdc_pkg::S_MODE: begin
        mul_a = $signed({19'b0, kp_gain_q});
        mul_b = tilt_q;
        if ((mode_q == btdc_pkg::MODE_FWD && !go_rev) ||
            (mode_q == btdc_pkg::MODE_REV && !go_fwd)) begin
          state_d = btdc_pkg::S_KP;
        end else begin
          state_d = btdc_pkg::S_OUT;
        end
      end
      btdc_pkg::S_KP: begin
        mul_a   = prod[btdc_pkg::MulAW-1:0];
        mul_b   = $signed({8'b0, lim});
        state_d = btdc_pkg::S_LIM;
      end
      btdc_pkg::S_LIM: begin
        mul_a          = $signed({19'b0, kd_gain_q});
        mul_b          = btdc_pkg::MulBW'(gz_q);
        div_ctrl.start = 1'b1;
        state_d        = btdc_pkg::S_DIV;
      end
      btdc_pkg::S_DIV: begin
        mul_a = $signed({19'b0, kd_gain_q});
        mul_b = btdc_pkg::MulBW'(gz_q);
        if (div_done) state_d = btdc_pkg::S_DRV;
      end
      btdc_pkg::S_DRV: state_d = btdc_pkg::S_OUT;
      btdc_pkg::S_OUT: if (out_o.ready) state_d = btdc_pkg::S_IDLE;
      default: state_d = btdc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= btdc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= btdc_pkg::MODE_INIT;
      accel_filt_q <= '0;
      gyro_filt_q  <= '0;
      pos_ext_q    <= 18'sd26;
      neg_ext_q    <= -18'sd26;
      fwd_hold_q   <= '0;
      rev_hold_q   <= '0;
      cnt_q        <= '0;
      drv_rev_q    <= 1'b0;
    end else begin
      unique case (state_q)
        btdc_pkg::S_IDLE: cnt_q <= '0;
        btdc_pkg::S_CORD: cnt_q <= cnt_q + 1'b1;
        btdc_pkg::S_GA:   accel_filt_q <= filt_new;
        btdc_pkg::S_TILT: gyro_filt_q <= filt_new;
        btdc_pkg::S_MODE: begin
          drv_rev_q <= (mode_q == btdc_pkg::MODE_REV);
          unique case (mode_q)
            btdc_pkg::MODE_INIT: begin
              fwd_hold_q <= '0;
              rev_hold_q <= '0;
              if (tilt_q > 0 && tilt_q > pos_ext_q) pos_ext_q <= tilt_q;
              if (tilt_q < 0 && tilt_q < neg_ext_q) neg_ext_q <= tilt_q;
              if (btn_q) mode_q <= btdc_pkg::MODE_STOP;
            end
            btdc_pkg::MODE_STOP: begin
              fwd_hold_q <= '0;
              rev_hold_q <= '0;
              if (btn_q) begin
                mode_q <= btdc_pkg::MODE_INIT;
              end else if (go_fwd) begin
                mode_q <= btdc_pkg::MODE_FWD;
              end else if (go_rev) begin
                mode_q <= btdc_pkg::MODE_REV;
              end
            end
            btdc_pkg::MODE_FWD: if (go_rev) mode_q <= btdc_pkg::MODE_REV;
            btdc_pkg::MODE_REV: if (go_fwd) mode_q <= btdc_pkg::MODE_FWD;
            default: ;
          endcase
        end
        btdc_pkg::S_DRV: begin
          if (drv_rev_q) begin
            rev_hold_q <= drv;
            fwd_hold_q <= '0;
          end else begin
            fwd_hold_q <= drv;
            rev_hold_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      btdc_pkg::S_IDLE: begin
        gz_q   <= in_i.gyro_z;
        btn_q  <= in_i.button;
        zero_q <= (in_i.accel_x == 16'sd0) && (in_i.accel_y == 16'sd0);
        cx_q   <= x0;
        cy_q   <= y0;
        cz_q   <= z0;
      end
      btdc_pkg::S_CORD: begin
        cx_q <= nx;
        cy_q <= ny;
        cz_q <= nz;
      end
      btdc_pkg::S_GYR:  acc_ang_q <= acc_ang;
      btdc_pkg::S_FA:   gyr_q <= gyr;
      btdc_pkg::S_FB:   acc_q <= prod[39:0];
      btdc_pkg::S_GB:   acc_q <= prod[39:0];
      btdc_pkg::S_TILT: tilt_q <= tilt_new;
      default: ;
    endcase
  end

  assign in_i.ready      = (state_q == btdc_pkg::S_IDLE);
  assign out_o.valid     = (state_q == btdc_pkg::S_OUT);
  assign out_o.fwd_drive = fwd_hold_q;
  assign out_o.rev_drive = rev_hold_q;
  assign out_o.mode      = mode_q;
  assign out_o.tilt      = tilt_q;

  // one request in flight at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("request accepted while busy");

  a_no_accept_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready)
    else $error("ready while a result waits");

  a_one_drive_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.fwd_drive != '0 && out_o.rev_drive != '0))
    else $error("both drives active");

  a_div_only_on_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctrl.start |-> (mode_q == btdc_pkg::MODE_FWD || mode_q == btdc_pkg::MODE_REV))
    else $error("drive divide outside a drive mode");

endmodule

FILE: design/btdc_mul.sv
`timescale 1ns / 1ps

module btdc_mul (
  input  logic                                clk_i,
  input  logic signed [btdc_pkg::MulAW-1:0]   a_i,
  input  logic signed [btdc_pkg::MulBW-1:0]   b_i,
  output logic signed [btdc_pkg::MulPW-1:0]   prod_o
);

  logic signed [btdc_pkg::MulPW-1:0] prod_q;

  // registered signed product
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

FILE: design/btdc_div.sv
`timescale 1ns / 1ps

module btdc_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  btdc_pkg::div_ctrl_t                 ctrl_i,
  input  logic signed [btdc_pkg::NumW-1:0]    num_i,
  input  logic signed [btdc_pkg::DenW-1:0]    den_i,
  output logic                                done_o,
  output logic signed [btdc_pkg::NumW-1:0]    quot_o
);

  localparam int NumW = btdc_pkg::NumW;
  localparam int DenW = btdc_pkg::DenW;
  localparam int CntW = $clog2(NumW);

  logic                   busy_q;
  logic                   done_q;
  logic [CntW-1:0]        cnt_q;
  logic [NumW-1:0]        nmag_q;
  logic [DenW-1:0]        dmag_q;
  logic [DenW-1:0]        rem_q;
  logic                   neg_q;
  logic signed [NumW-1:0] quot_q;

  logic [DenW:0]   trial;
  logic            qbit;
  logic [DenW:0]   rem_sub;
  logic [NumW-1:0] q_final;

  // one restoring step per cycle
  always_comb begin
    trial   = {rem_q, nmag_q[NumW-1]};
    qbit    = (trial >= {1'b0, dmag_q});
    rem_sub = qbit ? (trial - {1'b0, dmag_q}) : trial;
    q_final = {nmag_q[NumW-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(NumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operand magnitudes, quotient shifts into the numerator register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      nmag_q <= num_i[NumW-1] ? NumW'(-num_i) : NumW'(num_i);
      dmag_q <= den_i[DenW-1] ? DenW'(-den_i) : DenW'(den_i);
      rem_q  <= '0;
      neg_q  <= num_i[NumW-1] ^ den_i[DenW-1];
    end else if (busy_q) begin
      nmag_q <= q_final;
      rem_q  <= rem_sub[DenW-1:0];
      if (cnt_q == CntW'(NumW - 1)) begin
        quot_q <= neg_q ? -$signed(q_final) : $signed(q_final);
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

  typedef struct {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] gz;
    logic               btn;
  } sensor_t;

  typedef struct {
    logic [9:0]       fwd;
    logic [9:0]       rev;
    btdc_pkg::mode_e  mode;
    btdc_pkg::tilt_t  tilt;
  } drive_t;

  // tilt and drive predictor with its queue of pending drive results
  class tilt_drive_model;
    longint unsigned coef_a, coef_b, gyro_gain, kp_gain, kd_gain, pwm_max, dead_band;
    longint accel_filt, gyro_filt, pos_ext, neg_ext;
    btdc_pkg::mode_e cur_mode;
    logic [9:0] fwd_q, rev_q;
    drive_t pending_drives[$];
    int     errors;
    longint atan_deg[24] = '{2949120, 1740967, 919879, 466945, 234379, 117305, 58666,
                             29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                             57, 29, 14, 7, 4, 2, 1, 0};

    function new();
      coef_a = 324; coef_b = 32443; gyro_gain = 1000; kp_gain = 1580;
      kd_gain = 0; pwm_max = 1023; dead_band = 26;
      accel_filt = 0; gyro_filt = 0; pos_ext = 26; neg_ext = -26;
      cur_mode = btdc_pkg::MODE_INIT; fwd_q = '0; rev_q = '0; errors = 0;
    endfunction

    function void set_reg(btdc_pkg::reg_e idx, int unsigned val);
      case (idx)
        btdc_pkg::REG_COEF_A:    coef_a = val & 16'hFFFF;
        btdc_pkg::REG_COEF_B:    coef_b = val & 16'hFFFF;
        btdc_pkg::REG_GYRO_GAIN: gyro_gain = val & 16'hFFFF;
        btdc_pkg::REG_KP_GAIN:   kp_gain = val & 16'hFFFF;
        btdc_pkg::REG_KD_GAIN:   kd_gain = val & 16'hFFFF;
        btdc_pkg::REG_PWM_MAX:   pwm_max = val & 10'h3FF;
        btdc_pkg::REG_DEAD_BAND: dead_band = val & 12'hFFF;
        default: ;
      endcase
    endfunction

    function longint clip(longint v);
      if (v > 131071) return 131071;
      if (v < -131072) return -131072;
      return v;
    endfunction

    // vectoring atan2 in degree*65536
    function longint atan2_deg(longint y, longint x);
      longint z, nx, ny;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        z = (y >= 0) ? 180 * 65536 : -180 * 65536;
        x = -x;
        y = -y;
      end
      x = x * 256;
      y = y * 256;
      for (int i = 0; i < 16; i++) begin
        if (y > 0) begin
          nx = x + (y >>> i);
          ny = y - (x >>> i);
          z += atan_deg[i];
        end else begin
          nx = x - (y >>> i);
          ny = y + (x >>> i);
          z -= atan_deg[i];
        end
        x = nx;
        y = ny;
      end
      return z;
    endfunction

    function longint lowpass(longint fresh, longint old);
      longint s;
      s = longint'(coef_a) * fresh + longint'(coef_b) * old + 16384;
      return clip(s >>> 15);
    endfunction

    function logic [9:0] duty(longint tl, longint ext, longint gz);
      longint lim, d;
      lim = longint'(pwm_max);
      d = (longint'(kp_gain) * tl * lim) / ext;
      d = (d - longint'(kd_gain) * gz) / 256;
      if (d < 0) d = 0;
      if (d > lim) d = lim;
      return d[9:0];
    endfunction

    function void note_request(sensor_t s);
      longint acc, gyr, tl, db, gz;
      drive_t r;
      db = longint'(dead_band);
      gz = s.gz;
      acc = clip((-atan2_deg(longint'(s.ay), longint'(s.ax)) + 128) >>> 8);
      gyr = clip((gz * longint'(gyro_gain) + 128) >>> 8);
      accel_filt = lowpass(acc, accel_filt);
      gyro_filt = lowpass(gyr, gyro_filt);
      tl = clip(accel_filt + gyro_filt);
      case (cur_mode)
        btdc_pkg::MODE_INIT: begin
          fwd_q = '0; rev_q = '0;
          if (tl > 0 && tl > pos_ext) pos_ext = tl;
          if (tl < 0 && tl < neg_ext) neg_ext = tl;
          if (s.btn) cur_mode = btdc_pkg::MODE_STOP;
        end
        btdc_pkg::MODE_STOP: begin
          fwd_q = '0; rev_q = '0;
          if (tl >= db) cur_mode = btdc_pkg::MODE_FWD;
          else if (tl <= -db) cur_mode = btdc_pkg::MODE_REV;
          if (s.btn) cur_mode = btdc_pkg::MODE_INIT;
        end
        btdc_pkg::MODE_FWD: begin
          if (tl <= -db) cur_mode = btdc_pkg::MODE_REV;
          else begin
            fwd_q = duty(tl, pos_ext, gz);
            rev_q = '0;
          end
        end
        default: begin
          if (tl >= db) cur_mode = btdc_pkg::MODE_FWD;
          else begin
            rev_q = duty(tl, neg_ext, gz);
            fwd_q = '0;
          end
        end
      endcase
      r.fwd = fwd_q; r.rev = rev_q; r.mode = cur_mode; r.tilt = tl[17:0];
      pending_drives.push_back(r);
    endfunction

    function void check_result(drive_t got);
      drive_t e;
      if (pending_drives.size() == 0) begin
        $display("%0t unexpected result fwd %0d rev %0d mode %0d tilt %0d", $time,
                 got.fwd, got.rev, got.mode, got.tilt);
        errors++;
        return;
      end
      e = pending_drives.pop_front();
      if (got.fwd !== e.fwd) begin
        $display("%0t fwd_drive expected %0d actual %0d", $time, e.fwd, got.fwd);
        errors++;
      end
      if (got.rev !== e.rev) begin
        $display("%0t rev_drive expected %0d actual %0d", $time, e.rev, got.rev);
        errors++;
      end
      if (got.mode !== e.mode) begin
        $display("%0t mode expected %0d actual %0d", $time, e.mode, got.mode);
        errors++;
      end
      if (got.tilt !== e.tilt) begin
        $display("%0t tilt expected %0d actual %0d", $time, e.tilt, got.tilt);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  btdc_in_if  req_if ();
  btdc_out_if rsp_if ();

  balance_tilt_drive_controller_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (req_if.sink),
    .out_o      (rsp_if.source)
  );

  tilt_drive_model model = new();
  int burst_left;
  int lean;

  // clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // watch both channels
  always @(posedge clk_i) begin
    drive_t got;
    sensor_t s;
    if (req_if.valid && req_if.ready) begin
      s.ax = req_if.accel_x; s.ay = req_if.accel_y;
      s.gz = req_if.gyro_z;  s.btn = req_if.button;
      model.note_request(s);
    end
    if (rsp_if.valid && rsp_if.ready) begin
      got.fwd = rsp_if.fwd_drive; got.rev = rsp_if.rev_drive;
      got.mode = btdc_pkg::mode_e'(rsp_if.mode); got.tilt = rsp_if.tilt;
      model.check_result(got);
    end
  end

  // result stall pattern: free-running, coin flips, or long stalls
  int stall_style = 0;
  int stall_cnt = 0;
  int style_left = 0;
  always @(negedge clk_i) begin
    if (style_left == 0) begin
      stall_style = $urandom_range(0, 2);
      style_left = $urandom_range(20, 200);
    end
    style_left--;
    case (stall_style)
      0: rsp_if.ready = 1'b1;
      1: rsp_if.ready = $urandom_range(0, 1);
      default: begin
        if (stall_cnt > 0) begin
          stall_cnt--;
          rsp_if.ready = 1'b0;
        end else begin
          rsp_if.ready = 1'b1;
          if ($urandom_range(0, 3) == 0) stall_cnt = $urandom_range(1, 20);
        end
      end
    endcase
  end

  task automatic write_reg(btdc_pkg::reg_e idx, int unsigned val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val[15:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    model.set_reg(idx, val);
  endtask

  // present one request and hold it until taken, then maybe open a gap
  task automatic send_request(sensor_t s);
    req_if.valid = 1'b1;
    req_if.accel_x = s.ax;
    req_if.accel_y = s.ay;
    req_if.gyro_z = s.gz;
    req_if.button = s.btn;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
    if (burst_left > 0) burst_left--;
    else begin
      req_if.valid = 1'b0;
      repeat ($urandom_range(0, 10)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 8);
    end
  endtask

  task automatic send_fields(int ax, int ay, int gz, bit btn);
    sensor_t s;
    s.ax = ax; s.ay = ay; s.gz = gz; s.btn = btn;
    send_request(s);
  endtask

  // wait for every pending drive result, then idle before returning
  task automatic drain();
    req_if.valid = 1'b0;
    while (model.pending_drives.size() > 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  // mostly leaning sequences so the mode machine leaves init, with some noise
  task automatic random_request();
    sensor_t s;
    int mag;
    if ($urandom_range(0, 19) == 0) lean = $urandom_range(0, 2) - 1;
    if ($urandom_range(0, 4) == 0) begin
      s.ax = $urandom; s.ay = $urandom; s.gz = $urandom;
    end else begin
      mag = $urandom_range(1000, 32767);
      s.ax = ($urandom_range(0, 7) == 0) ? -mag : mag;
      s.ay = lean * $urandom_range(0, mag) + $urandom_range(0, 400) - 200;
      s.gz = ($urandom_range(0, 1)) ? $urandom : ($urandom_range(0, 2000) - 1000);
    end
    s.btn = ($urandom_range(0, 11) == 0);
    send_request(s);
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = btdc_pkg::REG_COEF_A;
    cfg_data_i = '0;
    req_if.valid = 1'b0;
    req_if.accel_x = '0;
    req_if.accel_y = '0;
    req_if.gyro_z = '0;
    req_if.button = 1'b0;
    rsp_if.ready = 1'b0;
    burst_left = 0;
    lean = 1;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: zero vector, field extremes, both folds, mode walk
    send_fields(0, 0, 0, 0);
    send_fields(32767, 32767, 32767, 0);
    send_fields(-32768, -32768, -32768, 0);
    send_fields(-32768, 0, 0, 0);
    send_fields(-100, 200, -5, 0);
    send_fields(-100, -200, 5, 0);
    send_fields(0, 32767, 0, 0);
    send_fields(0, -32768, 0, 1);
    drain();
    write_reg(btdc_pkg::REG_COEF_A, 32768);
    write_reg(btdc_pkg::REG_COEF_B, 0);
    write_reg(btdc_pkg::REG_KD_GAIN, 65535);
    for (int i = 0; i < 4; i++) send_fields(10000, -3000, 0, 0);
    send_fields(10000, 3000, 0, 1);
    send_fields(10000, -3000, 0, 0);
    send_fields(10000, -3000, 100, 0);
    send_fields(10000, 3000, -100, 0);
    send_fields(10000, 3000, 32767, 0);
    send_fields(10000, -3000, -32768, 0);
    send_fields(10000, 0, 0, 0);
    send_fields(10000, 0, 0, 0);
    drain();

    // phases through several register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(btdc_pkg::REG_COEF_A, 32768); write_reg(btdc_pkg::REG_COEF_B, 0);
          write_reg(btdc_pkg::REG_GYRO_GAIN, 0); write_reg(btdc_pkg::REG_KP_GAIN, 65535);
          write_reg(btdc_pkg::REG_KD_GAIN, 0); write_reg(btdc_pkg::REG_PWM_MAX, 1023);
          write_reg(btdc_pkg::REG_DEAD_BAND, 0);
        end
        1: begin
          write_reg(btdc_pkg::REG_COEF_A, 16384); write_reg(btdc_pkg::REG_COEF_B, 16384);
          write_reg(btdc_pkg::REG_GYRO_GAIN, 65535);
          write_reg(btdc_pkg::REG_KP_GAIN, 1580);
          write_reg(btdc_pkg::REG_KD_GAIN, 65535); write_reg(btdc_pkg::REG_PWM_MAX, 1);
          write_reg(btdc_pkg::REG_DEAD_BAND, 2560);
        end
        2: begin
          write_reg(btdc_pkg::REG_COEF_A, 32768); write_reg(btdc_pkg::REG_COEF_B, 32768);
          write_reg(btdc_pkg::REG_GYRO_GAIN, 1000); write_reg(btdc_pkg::REG_KP_GAIN, 0);
          write_reg(btdc_pkg::REG_KD_GAIN, 300); write_reg(btdc_pkg::REG_PWM_MAX, 500);
          write_reg(btdc_pkg::REG_DEAD_BAND, 26);
        end
        3: begin
          write_reg(btdc_pkg::REG_COEF_A, 0); write_reg(btdc_pkg::REG_COEF_B, 32768);
          write_reg(btdc_pkg::REG_GYRO_GAIN, 256); write_reg(btdc_pkg::REG_PWM_MAX, 1023);
        end
        default: begin
          write_reg(btdc_pkg::REG_COEF_A, $urandom_range(8000, 32768));
          write_reg(btdc_pkg::REG_COEF_B, $urandom_range(0, 24000));
          write_reg(btdc_pkg::REG_GYRO_GAIN, $urandom_range(0, 65535));
          write_reg(btdc_pkg::REG_KP_GAIN, $urandom_range(0, 65535));
          write_reg(btdc_pkg::REG_KD_GAIN, $urandom_range(0, 65535));
          write_reg(btdc_pkg::REG_PWM_MAX, $urandom_range(1, 1023));
          write_reg(btdc_pkg::REG_DEAD_BAND, $urandom_range(0, 2560));
        end
      endcase
      for (int i = 0; i < 100; i++) random_request();
      drain();
    end

    if (model.errors == 0 && model.pending_drives.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // run limit
  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule
